// ===== rtl/core/uer_pkg.sv =====
// Shared types and constants for the ultrasonic echo ranger.
// No dependencies; used by rtl/core/ultrasonic_echo_ranger.sv.
package uer_pkg;

  // trigger pulse shape, in ticks
  localparam int unsigned TRIG_LOW_TICKS  = 2;
  localparam int unsigned TRIG_HIGH_TICKS = 10;

  localparam int unsigned CNT_W  = 17;
  localparam int unsigned DIST_W = 14;
  localparam int unsigned TMO_W  = 16;
  localparam int unsigned STAT_W = 3;
  localparam int unsigned ADDR_W = 5;
  localparam int unsigned DATA_W = 32;

  localparam logic [CNT_W-1:0]  CNT_MAX  = '1;
  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  // width*17 fits in 22 bits; floor(x/100) = (x*DIV_MUL) >> DIV_SHIFT for x < 2^22
  localparam int unsigned PROD_W    = 22;
  localparam int unsigned MUL_W     = 23;
  localparam int unsigned DIV_SHIFT = 29;
  localparam logic [MUL_W-1:0] DIV_MUL = 23'd5368710;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_TLOW  = 3'd1,
    PH_THIGH = 3'd2,
    PH_WAIT  = 3'd3,
    PH_MEAS  = 3'd4
  } phase_t;

  localparam logic [STAT_W-1:0] ST_OK     = 3'd0;
  localparam logic [STAT_W-1:0] ST_NOINIT = 3'd1;
  localparam logic [STAT_W-1:0] ST_NORISE = 3'd2;
  localparam logic [STAT_W-1:0] ST_STUCK  = 3'd3;
  localparam logic [STAT_W-1:0] ST_RANGE  = 3'd4;

  // register index = paddr[4:2]
  localparam logic [2:0] REG_ENABLE   = 3'd0;
  localparam logic [2:0] REG_MIN_DIST = 3'd1;
  localparam logic [2:0] REG_MAX_DIST = 3'd2;
  localparam logic [2:0] REG_RISE_TMO = 3'd3;
  localparam logic [2:0] REG_ECHO_TMO = 3'd4;

  typedef struct packed {
    logic              trig_level;
    logic              busy_res;
    logic              done_res;
    logic [DIST_W-1:0] distance;
    logic [STAT_W-1:0] status;
  } res_t;

endpackage

// ===== rtl/core/ultrasonic_echo_ranger.sv =====
// Ultrasonic echo ranger: trigger/echo sensor controller, one request per microsecond tick.
// Each result is registered into the result register, or into the skid entry while the output is held.
// Throughput: one request per cycle unless stalled; phase update is a single registered step per request,
// with a two-entry output buffer (result register plus skid); requests stall only when both are full.
// Reset (rst, synchronous): phase idle, counter 0, status uninitialized, registers to defaults.
module ultrasonic_echo_ranger (
  input  logic                          clk,
  input  logic                          rst,
  // request channel
  input  logic                          req_valid,
  output logic                          req_stall,
  input  logic                          start_req,
  input  logic                          echo_level,
  // result channel
  output logic                          res_valid,
  input  logic                          res_stall,
  output logic                          trig_level,
  output logic                          busy_res,
  output logic                          done_res,
  output logic [uer_pkg::DIST_W-1:0]    distance,
  output logic [uer_pkg::STAT_W-1:0]    status,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [uer_pkg::ADDR_W-1:0]    paddr,
  input  logic [uer_pkg::DATA_W-1:0]    pwdata,
  output logic [uer_pkg::DATA_W-1:0]    prdata,
  output logic                          pready
);

  // ---------------- configuration registers ----------------
  logic                       enable;
  logic [uer_pkg::DIST_W-1:0] min_distance;
  logic [uer_pkg::DIST_W-1:0] max_distance;
  logic [uer_pkg::TMO_W-1:0]  rise_timeout;
  logic [uer_pkg::TMO_W-1:0]  echo_timeout;
  logic                       cfg_wr;
  logic [2:0]                 cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[4:2];
  assign cfg_wr  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      enable       <= 1'b0;
      min_distance <= 14'd20;
      max_distance <= 14'd4000;
      rise_timeout <= 16'd1000;
      echo_timeout <= 16'd23200;
    end else if (cfg_wr) begin
      case (cfg_idx)
        uer_pkg::REG_ENABLE:   enable       <= pwdata[0];
        uer_pkg::REG_MIN_DIST: min_distance <= pwdata[uer_pkg::DIST_W-1:0];
        uer_pkg::REG_MAX_DIST: max_distance <= pwdata[uer_pkg::DIST_W-1:0];
        uer_pkg::REG_RISE_TMO: rise_timeout <= pwdata[uer_pkg::TMO_W-1:0];
        uer_pkg::REG_ECHO_TMO: echo_timeout <= pwdata[uer_pkg::TMO_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      uer_pkg::REG_ENABLE:   prdata = {31'd0, enable};
      uer_pkg::REG_MIN_DIST: prdata = {18'd0, min_distance};
      uer_pkg::REG_MAX_DIST: prdata = {18'd0, max_distance};
      uer_pkg::REG_RISE_TMO: prdata = {16'd0, rise_timeout};
      uer_pkg::REG_ECHO_TMO: prdata = {16'd0, echo_timeout};
      default:               prdata = '0;
    endcase
  end

  // ---------------- handshake / output buffer ----------------
  logic          accept;
  logic          res_take;
  logic          skid_valid;
  uer_pkg::res_t res_q;
  uer_pkg::res_t skid_q;
  uer_pkg::res_t res_next;

  assign req_stall = skid_valid;
  assign accept    = req_valid & ~req_stall;
  assign res_take  = res_valid & ~res_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (res_take) begin
        skid_valid <= 1'b0;
      end
    end else if (accept) begin
      if (res_valid && !res_take) begin
        skid_valid <= 1'b1;
      end else begin
        res_valid <= 1'b1;
      end
    end else if (res_take) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (res_take) begin
        res_q <= skid_q;
      end
    end else if (accept) begin
      if (res_valid && !res_take) begin
        skid_q <= res_next;
      end else begin
        res_q <= res_next;
      end
    end
  end

  assign trig_level = res_q.trig_level;
  assign busy_res   = res_q.busy_res;
  assign done_res   = res_q.done_res;
  assign distance   = res_q.distance;
  assign status     = res_q.status;

  // ---------------- measurement state ----------------
  uer_pkg::phase_t             phase, phase_next;
  logic [uer_pkg::CNT_W-1:0]   tick_count, tick_count_next;
  logic [uer_pkg::STAT_W-1:0]  last_status, last_status_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= uer_pkg::PH_IDLE;
      tick_count  <= '0;
      last_status <= uer_pkg::ST_NOINIT;
    end else if (accept) begin
      phase       <= phase_next;
      tick_count  <= tick_count_next;
      last_status <= last_status_next;
    end
  end

  // distance = floor(width*17/100), saturated to 14 bits
  logic [uer_pkg::PROD_W-1:0]              width17;
  logic [uer_pkg::PROD_W+uer_pkg::MUL_W-1:0] div_prod;
  logic [uer_pkg::PROD_W+uer_pkg::MUL_W-uer_pkg::DIV_SHIFT-1:0] quot;
  logic [uer_pkg::DIST_W-1:0]              dist_sat;
  logic                                    dist_bad;

  assign width17  = {tick_count, 4'd0} + uer_pkg::PROD_W'(tick_count);
  assign div_prod = width17 * uer_pkg::DIV_MUL;
  assign quot     = div_prod[uer_pkg::PROD_W+uer_pkg::MUL_W-1:uer_pkg::DIV_SHIFT];
  assign dist_sat = (quot > {2'b00, uer_pkg::DIST_MAX}) ? uer_pkg::DIST_MAX
                                                       : quot[uer_pkg::DIST_W-1:0];
  assign dist_bad = (dist_sat < min_distance) || (dist_sat > max_distance);

  logic [uer_pkg::CNT_W-1:0] cnt_inc;
  logic [uer_pkg::CNT_W-1:0] echo_tmo_x;
  logic [uer_pkg::CNT_W-1:0] rise_tmo_x;

  assign cnt_inc    = (tick_count == uer_pkg::CNT_MAX) ? uer_pkg::CNT_MAX : tick_count + 1'b1;
  assign echo_tmo_x = {1'b0, echo_timeout};
  assign rise_tmo_x = {1'b0, rise_timeout};

  always_comb begin
    logic                      done;
    logic                      trig;
    logic [uer_pkg::DIST_W-1:0] dist_val;
    phase_next       = phase;
    tick_count_next  = tick_count;
    last_status_next = last_status;
    done             = 1'b0;
    trig             = 1'b0;
    dist_val         = '0;
    case (phase)
      uer_pkg::PH_IDLE: begin
        if (start_req) begin
          if (!enable) begin
            last_status_next = uer_pkg::ST_NOINIT;
            done             = 1'b1;
          end else if (uer_pkg::CNT_W'(1) >= uer_pkg::CNT_W'(uer_pkg::TRIG_LOW_TICKS)) begin
            phase_next      = uer_pkg::PH_THIGH;
            tick_count_next = '0;
          end else begin
            phase_next      = uer_pkg::PH_TLOW;
            tick_count_next = uer_pkg::CNT_W'(1);
          end
        end
      end
      uer_pkg::PH_TLOW: begin
        if (cnt_inc >= uer_pkg::CNT_W'(uer_pkg::TRIG_LOW_TICKS)) begin
          phase_next      = uer_pkg::PH_THIGH;
          tick_count_next = '0;
        end else begin
          tick_count_next = cnt_inc;
        end
      end
      uer_pkg::PH_THIGH: begin
        trig = 1'b1;
        if (cnt_inc >= uer_pkg::CNT_W'(uer_pkg::TRIG_HIGH_TICKS)) begin
          phase_next      = uer_pkg::PH_WAIT;
          tick_count_next = '0;
        end else begin
          tick_count_next = cnt_inc;
        end
      end
      uer_pkg::PH_WAIT: begin
        if (echo_level) begin
          // rising tick counts as width 1; a zero echo timeout fails at once
          if (echo_tmo_x == '0) begin
            last_status_next = uer_pkg::ST_STUCK;
            phase_next       = uer_pkg::PH_IDLE;
            tick_count_next  = '0;
            done             = 1'b1;
          end else begin
            phase_next      = uer_pkg::PH_MEAS;
            tick_count_next = uer_pkg::CNT_W'(1);
          end
        end else if (cnt_inc > rise_tmo_x) begin
          last_status_next = uer_pkg::ST_NORISE;
          phase_next       = uer_pkg::PH_IDLE;
          tick_count_next  = '0;
          done             = 1'b1;
        end else begin
          tick_count_next = cnt_inc;
        end
      end
      uer_pkg::PH_MEAS: begin
        if (echo_level) begin
          if (cnt_inc > echo_tmo_x) begin
            last_status_next = uer_pkg::ST_STUCK;
            phase_next       = uer_pkg::PH_IDLE;
            tick_count_next  = '0;
            done             = 1'b1;
          end else begin
            tick_count_next = cnt_inc;
          end
        end else begin
          if (dist_bad) begin
            last_status_next = uer_pkg::ST_RANGE;
          end else begin
            last_status_next = uer_pkg::ST_OK;
            dist_val         = dist_sat;
          end
          phase_next      = uer_pkg::PH_IDLE;
          tick_count_next = '0;
          done            = 1'b1;
        end
      end
      default: begin
        phase_next      = uer_pkg::PH_IDLE;
        tick_count_next = '0;
      end
    endcase
    res_next.trig_level = trig;
    res_next.busy_res   = (phase_next != uer_pkg::PH_IDLE);
    res_next.done_res   = done;
    res_next.distance   = dist_val;
    res_next.status     = last_status_next;
  end

`ifndef SYNTHESIS
  // skid entry only fills behind a held result
  a_skid_behind_res: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> res_valid)
    else $error("skid holds a result while output register is empty");

  a_dist_only_ok: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_q.distance != '0) |->
      (res_q.done_res && res_q.status == uer_pkg::ST_OK))
    else $error("nonzero distance outside an ok completion");

  a_trig_while_busy: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_q.trig_level) |-> res_q.busy_res)
    else $error("trigger driven while idle");

  a_fall_ends_meas: assert property (@(posedge clk) disable iff (rst)
    (accept && phase == uer_pkg::PH_MEAS && !echo_level) |=> phase == uer_pkg::PH_IDLE)
    else $error("echo fall did not end the measurement");

  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_q.done_res) |-> !res_q.busy_res)
    else $error("completion reported while still busy");
`endif

endmodule

// ===== tb/tb_ultrasonic_echo_ranger.sv =====
// Self-checking testbench for ultrasonic_echo_ranger: tick requests in, one result per tick out.
// Depends on rtl/core/uer_pkg.sv and rtl/core/ultrasonic_echo_ranger.sv; a scoreboard class
// tracks the ranging state and checks every result in order.
`timescale 1ns / 1ps

module tb_ultrasonic_echo_ranger;
  import uer_pkg::*;

  localparam int QUIET_LIMIT     = 1000;
  localparam int NUM_PHASES      = 13;
  localparam int ITEMS_PER_PHASE = 100;
  localparam int WAIT_CAP        = 20;
  localparam int WIDTH_CAP       = 70;
  localparam int PRINT_CAP       = 50;

  // Tracks the ranger's phase, tick counter and status, and holds results still due.
  class ranging_tracker;
    bit                enabled;
    logic [DIST_W-1:0] min_mm, max_mm;
    logic [TMO_W-1:0]  rise_limit, echo_limit;
    phase_t            phase_now;
    logic [CNT_W-1:0]  ticks;
    logic [STAT_W-1:0] last_st;
    res_t              due_results[$];
    int                errors;
    int                checked;

    function new();
      enabled    = 1'b0;
      min_mm     = 14'd20;
      max_mm     = 14'd4000;
      rise_limit = 16'd1000;
      echo_limit = 16'd23200;
      phase_now  = PH_IDLE;
      ticks      = '0;
      last_st    = ST_NOINIT;
      errors     = 0;
      checked    = 0;
    endfunction

    task report(string msg);
      if (errors < PRINT_CAP) $display("MISMATCH: %s", msg);
      errors++;
    endtask

    function void write_reg(logic [2:0] idx, logic [DATA_W-1:0] v);
      case (idx)
        REG_ENABLE:   enabled = v[0];
        REG_MIN_DIST: min_mm = v[DIST_W-1:0];
        REG_MAX_DIST: max_mm = v[DIST_W-1:0];
        REG_RISE_TMO: rise_limit = v[TMO_W-1:0];
        REG_ECHO_TMO: echo_limit = v[TMO_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [DATA_W-1:0] reg_value(logic [2:0] idx);
      case (idx)
        REG_ENABLE:   return DATA_W'(enabled);
        REG_MIN_DIST: return DATA_W'(min_mm);
        REG_MAX_DIST: return DATA_W'(max_mm);
        REG_RISE_TMO: return DATA_W'(rise_limit);
        REG_ECHO_TMO: return DATA_W'(echo_limit);
        default:      return '0;
      endcase
    endfunction

    function logic [CNT_W-1:0] bump(logic [CNT_W-1:0] c);
      return (c == CNT_MAX) ? CNT_MAX : c + 1'b1;
    endfunction

    function bit busy();
      return phase_now != PH_IDLE;
    endfunction

    function int pending();
      return due_results.size();
    endfunction

    // Advance one tick and queue the result it produces.
    function void note_request(bit start, bit echo);
      res_t        r;
      int unsigned mm;
      r = '0;
      case (phase_now)
        PH_IDLE: begin
          if (start) begin
            if (!enabled) begin
              last_st = ST_NOINIT;
              r.done_res = 1'b1;
            end else begin
              ticks = CNT_W'(1);
              phase_now = PH_TLOW;
              if (ticks >= TRIG_LOW_TICKS) begin
                phase_now = PH_THIGH;
                ticks = '0;
              end
            end
          end
        end
        PH_TLOW: begin
          ticks = bump(ticks);
          if (ticks >= TRIG_LOW_TICKS) begin
            phase_now = PH_THIGH;
            ticks = '0;
          end
        end
        PH_THIGH: begin
          r.trig_level = 1'b1;
          ticks = bump(ticks);
          if (ticks >= TRIG_HIGH_TICKS) begin
            phase_now = PH_WAIT;
            ticks = '0;
          end
        end
        PH_WAIT: begin
          if (echo) begin
            // rising tick counts as width 1 and is checked against the stuck limit
            ticks = CNT_W'(1);
            phase_now = PH_MEAS;
            if (ticks > echo_limit) begin
              last_st = ST_STUCK;
              phase_now = PH_IDLE;
              ticks = '0;
              r.done_res = 1'b1;
            end
          end else begin
            ticks = bump(ticks);
            if (ticks > rise_limit) begin
              last_st = ST_NORISE;
              phase_now = PH_IDLE;
              ticks = '0;
              r.done_res = 1'b1;
            end
          end
        end
        PH_MEAS: begin
          if (echo) begin
            ticks = bump(ticks);
            if (ticks > echo_limit) begin
              last_st = ST_STUCK;
              phase_now = PH_IDLE;
              ticks = '0;
              r.done_res = 1'b1;
            end
          end else begin
            mm = (32'(ticks) * 17) / 100;
            if (mm > DIST_MAX) mm = DIST_MAX;
            if (mm < min_mm || mm > max_mm) begin
              last_st = ST_RANGE;
            end else begin
              last_st = ST_OK;
              r.distance = DIST_W'(mm);
            end
            phase_now = PH_IDLE;
            ticks = '0;
            r.done_res = 1'b1;
          end
        end
        default: begin
          phase_now = PH_IDLE;
          ticks = '0;
        end
      endcase
      r.busy_res = (phase_now != PH_IDLE);
      r.status = last_st;
      due_results.push_back(r);
    endfunction

    task check_result(res_t got);
      res_t want;
      if (due_results.size() == 0) begin
        report($sformatf("result %0d arrived with nothing expected", checked));
      end else begin
        want = due_results.pop_front();
        if (got.trig_level !== want.trig_level)
          report($sformatf("result %0d trig_level got %0b want %0b", checked,
                           got.trig_level, want.trig_level));
        if (got.busy_res !== want.busy_res)
          report($sformatf("result %0d busy_res got %0b want %0b", checked,
                           got.busy_res, want.busy_res));
        if (got.done_res !== want.done_res)
          report($sformatf("result %0d done_res got %0b want %0b", checked,
                           got.done_res, want.done_res));
        if (got.distance !== want.distance)
          report($sformatf("result %0d distance got %0d want %0d", checked,
                           got.distance, want.distance));
        if (got.status !== want.status)
          report($sformatf("result %0d status got %0d want %0d", checked,
                           got.status, want.status));
      end
      checked++;
    endtask
  endclass

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              req_valid = 1'b0;
  logic              req_stall;
  logic              start_req = 1'b0;
  logic              echo_level = 1'b0;
  logic              res_valid;
  logic              res_stall = 1'b0;
  logic              trig_level;
  logic              busy_res;
  logic              done_res;
  logic [DIST_W-1:0] distance;
  logic [STAT_W-1:0] status;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  ranging_tracker sb = new();
  bit idling = 1'b1;
  int items_sent = 0;
  int stall_left = 0;
  int quiet_cycles = 0;

  ultrasonic_echo_ranger dut (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .start_req  (start_req),
    .echo_level (echo_level),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .trig_level (trig_level),
    .busy_res   (busy_res),
    .done_res   (done_res),
    .distance   (distance),
    .status     (status),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always #1 clk = ~clk;

  // result-side backpressure in short bursts
  always @(posedge clk) begin
    if (rst || !idling) begin
      stall_left = 0;
      res_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      res_stall <= 1'b1;
    end else if ($urandom_range(0, 6) == 0) begin
      stall_left = $urandom_range(0, 3);
      res_stall <= 1'b1;
    end else begin
      res_stall <= 1'b0;
    end
  end

  // result monitor and watchdog
  always @(posedge clk) begin
    res_t got;
    if (!rst) begin
      if (res_valid && !res_stall) begin
        got.trig_level = trig_level;
        got.busy_res   = busy_res;
        got.done_res   = done_res;
        got.distance   = distance;
        got.status     = status;
        sb.check_result(got);
      end
      if ((res_valid && !res_stall) || (req_valid && !req_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles", QUIET_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  task automatic send(bit s, bit e);
    int gap;
    if (idling && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 4);
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid  <= 1'b1;
    start_req  <= s;
    echo_level <= e;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    sb.note_request(s, e);
    items_sent++;
  endtask

  task automatic drain();
    req_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic reg_write(logic [2:0] idx, logic [DATA_W-1:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.write_reg(idx, v);
  endtask

  task automatic reg_check(logic [2:0] idx);
    logic [DATA_W-1:0] v;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    v = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (v !== sb.reg_value(idx))
      sb.report($sformatf("register %0d read 0x%0h want 0x%0h", idx, v, sb.reg_value(idx)));
  endtask

  task automatic apply_config(bit en, int mn, int mx, int rt, int et);
    reg_write(REG_ENABLE, DATA_W'(en));
    reg_write(REG_MIN_DIST, DATA_W'(mn));
    reg_write(REG_MAX_DIST, DATA_W'(mx));
    reg_write(REG_RISE_TMO, DATA_W'(rt));
    reg_write(REG_ECHO_TMO, DATA_W'(et));
    for (int i = int'(REG_ENABLE); i <= int'(REG_ECHO_TMO); i++) reg_check(3'(i));
  endtask

  // start tick plus the rest of the trigger pulse; starts here land while busy
  task automatic fire_trigger();
    send(1'b1, 1'($urandom_range(0, 1)));
    repeat (TRIG_LOW_TICKS + TRIG_HIGH_TICKS - 1)
      send(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
  endtask

  task automatic run_measurement(int wait_lo, int width);
    fire_trigger();
    repeat (wait_lo) send(1'b0, 1'b0);
    repeat (width) send(1'b0, 1'b1);
    send(1'b0, 1'b0);
  endtask

  // bring the ranger back to idle: a high then a low echo ends any wait
  task automatic settle();
    while (sb.busy()) send(1'b0, sb.phase_now == PH_WAIT);
  endtask

  initial begin
    int phase_start;
    int roll;
    int n;
    int mn, mx, rt, et;
    int wcap, hcap;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // disabled after reset: a start is refused at once
    send(1'b1, 1'b1);
    send(1'b0, 1'b0);
    drain();

    // writes past the register list must leave everything alone
    for (int i = int'(REG_ECHO_TMO) + 1; i < 2 ** (ADDR_W - 2); i++) reg_write(3'(i), '1);
    for (int i = int'(REG_ENABLE); i <= int'(REG_ECHO_TMO); i++) reg_check(3'(i));
    send(1'b1, 1'b0);
    drain();

    // zero timeouts: first low sample after the pulse times out the rise wait
    apply_config(1'b1, 0, DIST_MAX, 0, 0);
    run_measurement(0, 0);
    drain();

    // enable dropped mid-measurement; the running one still ends (stuck on the rise)
    fire_trigger();
    drain();
    reg_write(REG_ENABLE, '0);
    send(1'b0, 1'b1);
    send(1'b1, 1'b0);
    drain();

    for (int p = 0; p < NUM_PHASES; p++) begin
      idling = 1'b1;
      settle();
      drain();
      case ($urandom_range(0, 5))
        0: begin mn = 0; mx = DIST_MAX; end
        1: begin mn = DIST_MAX; mx = 0; end
        default: begin mn = $urandom_range(0, 6); mx = $urandom_range(0, 12); end
      endcase
      case ($urandom_range(0, 5))
        0: rt = 0;
        1: rt = 16'hFFFF;
        default: rt = $urandom_range(0, 25);
      endcase
      case ($urandom_range(0, 5))
        0: et = 0;
        1: et = 16'hFFFF;
        default: et = $urandom_range(0, WIDTH_CAP);
      endcase
      if (p == 0) begin mn = 0; mx = DIST_MAX; rt = 16'hFFFF; et = 16'hFFFF; end
      if (p == 1) begin mn = DIST_MAX; mx = 0; rt = 0; et = 0; end
      apply_config(p != 4, mn, mx, rt, et);
      idling = (p >= NUM_PHASES - 2) ? 1'b0 : ($urandom_range(0, 3) != 0);

      wcap = (rt + 1 < WAIT_CAP) ? rt + 1 : WAIT_CAP;
      hcap = (et + 1 < WIDTH_CAP) ? et + 1 : WIDTH_CAP;
      phase_start = items_sent;
      while (items_sent - phase_start < ITEMS_PER_PHASE) begin
        roll = $urandom_range(0, 9);
        if (roll < 8) begin
          run_measurement($urandom_range(0, wcap), $urandom_range(1, hcap));
        end else if (roll == 8) begin
          n = $urandom_range(4, 24);
          repeat (n) send(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end else begin
          // pulse fired, then the echo goes off the rails
          fire_trigger();
          n = $urandom_range(1, 8);
          repeat (n) send(1'b0, 1'($urandom_range(0, 1)));
        end
      end
      // an extra pause after phase 6, with the sender waiting for every result
      if (p == 6) drain();
    end

    drain();
    repeat (4) @(posedge clk);
    if (sb.pending() != 0) sb.report($sformatf("%0d results never arrived", sb.pending()));
    if (sb.errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/uer_pkg.sv
rtl/core/ultrasonic_echo_ranger.sv
tb/tb_ultrasonic_echo_ranger.sv
